[rtl/core/jkse_pkg.sv]
package jkse_pkg;

  // Result status codes
  localparam logic [1:0] ST_CHAR = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  // Register indexes (8-byte stride on the config port)
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  // Width of the key length register
  localparam int unsigned LEN_W = 5;

  // Result queue depth between front and back
  localparam int unsigned QDEPTH = 4;

  typedef struct packed {
    logic [7:0] char_out;
    logic [1:0] status;
    logic       run_end;
  } result_t;

  // Up to two results per accepted byte; v1 implies v0
  typedef struct packed {
    logic    v0;
    result_t r0;
    logic    v1;
    result_t r1;
  } push_t;

endpackage

[rtl/core/jkse_front.sv]
module jkse_front #(
  parameter int unsigned MAX_KEY_CHARS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    doc_last_i,
  input  logic [63:0]             key_low_i,
  input  logic [63:0]             key_high_i,
  input  logic [jkse_pkg::LEN_W-1:0] key_len_i,
  output jkse_pkg::push_t         push_o
);
  import jkse_pkg::*;

  localparam int unsigned DEPTH = MAX_KEY_CHARS + 2;
  localparam int unsigned FW    = $clog2(DEPTH + 1);

  // Parser phases
  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_COLON  = 3'd1;
  localparam logic [2:0] PH_SKIPWS = 3'd2;
  localparam logic [2:0] PH_STRING = 3'd3;
  localparam logic [2:0] PH_ESCAPE = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  // Byte constants
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;

  function automatic logic [7:0] unescape(input logic [7:0] e);
    logic [7:0] r;
    case (e)
      CH_LC_B: r = 8'h08;
      CH_LC_F: r = 8'h0C;
      CH_LC_N: r = 8'h0A;
      CH_LC_R: r = 8'h0D;
      CH_LC_T: r = 8'h09;
      default: r = e;
    endcase
    return r;
  endfunction

  logic [2:0]          phase_q, phase_d;
  logic [7:0]          win_q [DEPTH];
  logic [7:0]          win_new [DEPTH];
  logic [FW-1:0]       fill_q, fill_d, fill_inc;
  logic [LEN_W-1:0]    len, plen;
  logic [127:0]        key_all;
  logic                match;
  logic                is_space;
  push_t               push;

  // Effective key length, clamped to MAX_KEY_CHARS
  assign len  = (key_len_i > LEN_W'(MAX_KEY_CHARS)) ? LEN_W'(MAX_KEY_CHARS) : key_len_i;
  assign plen = len + LEN_W'(2);
  assign key_all = {key_high_i, key_low_i};

  assign is_space = (data_byte_i == CH_SPACE) || (data_byte_i inside {[8'd9:8'd13]});

  // Window after this byte is shifted in, newest at index 0
  always_comb begin
    win_new[0] = data_byte_i;
    for (int k = 1; k < DEPTH; k++) begin
      win_new[k] = win_q[k-1];
    end
  end

  assign fill_inc = (fill_q < FW'(DEPTH)) ? fill_q + FW'(1) : fill_q;

  // Parallel compare of the window against the quoted key
  always_comb begin
    logic [LEN_W-1:0] idx;
    logic [7:0]       pat;
    // plen never exceeds DEPTH, so it fits the fill width
    match = (fill_inc >= FW'(plen));
    for (int k = 0; k < DEPTH; k++) begin
      idx = len - LEN_W'(k);
      if ((k == 0) || (LEN_W'(k) == plen - LEN_W'(1))) begin
        pat = CH_QUOTE;
      end else begin
        pat = key_all[{idx[3:0], 3'b000} +: 8];
      end
      if ((LEN_W'(k) < plen) && (win_new[k] != pat)) begin
        match = 1'b0;
      end
    end
  end

  // Phase machine and result generation
  always_comb begin
    phase_d = phase_q;
    fill_d  = fill_q;
    push    = '0;
    if (accept_i) begin
      case (phase_q)
        PH_SEARCH: begin
          fill_d = fill_inc;
          if (match) phase_d = PH_COLON;
        end
        PH_COLON: begin
          if (data_byte_i == CH_COLON) phase_d = PH_SKIPWS;
        end
        PH_SKIPWS: begin
          if (!is_space) begin
            if (data_byte_i == CH_QUOTE) begin
              phase_d = PH_STRING;
            end else begin
              push.v0 = 1'b1;
              push.r0 = '{char_out: 8'h00, status: ST_FAIL, run_end: 1'b1};
              phase_d = PH_DONE;
            end
          end
        end
        PH_STRING: begin
          if (data_byte_i == CH_QUOTE) begin
            push.v0 = 1'b1;
            push.r0 = '{char_out: 8'h00, status: ST_DONE, run_end: 1'b1};
            phase_d = PH_DONE;
          end else if ((data_byte_i == CH_BSLASH) && !doc_last_i) begin
            phase_d = PH_ESCAPE;
          end else begin
            push.v0 = 1'b1;
            push.r0 = '{char_out: data_byte_i, status: ST_CHAR, run_end: 1'b0};
          end
        end
        PH_ESCAPE: begin
          push.v0 = 1'b1;
          push.r0 = '{char_out: unescape(data_byte_i), status: ST_CHAR, run_end: 1'b0};
          phase_d = PH_STRING;
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
      // End of document: fail if unfinished, then rearm
      if (doc_last_i) begin
        if (phase_d != PH_DONE) begin
          if (push.v0) begin
            push.v1 = 1'b1;
            push.r1 = '{char_out: 8'h00, status: ST_FAIL, run_end: 1'b1};
          end else begin
            push.v0 = 1'b1;
            push.r0 = '{char_out: 8'h00, status: ST_FAIL, run_end: 1'b1};
          end
        end
        phase_d = PH_SEARCH;
        fill_d  = '0;
      end
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      fill_q  <= '0;
    end else begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
    end
  end

  // Match window shifts only while searching
  always_ff @(posedge clk_i) begin
    if (accept_i && (phase_q == PH_SEARCH)) begin
      for (int k = 0; k < DEPTH; k++) begin
        win_q[k] <= win_new[k];
      end
    end
  end

endmodule

[rtl/core/jkse_back.sv]
module jkse_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jkse_pkg::push_t   push_i,
  output logic              room_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output jkse_pkg::result_t out_o
);
  import jkse_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  result_t       mem_q [QDEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] n_push;
  logic          pop;
  logic          out_valid_q;
  result_t       out_q;

  assign n_push = CW'(push_i.v0) + CW'(push_i.v1);
  assign pop    = (count_q != '0) && (!out_valid_q || !out_stall_i);
  // Front may push two results, so keep two slots free
  assign room_o = (count_q <= CW'(QDEPTH - 2));

  // Queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + PW'(n_push);
      rptr_q  <= rptr_q + PW'(pop);
      count_q <= count_q + n_push - CW'(pop);
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push_i.v0) mem_q[wptr_q] <= push_i.r0;
    if (push_i.v1) mem_q[wptr_q + PW'(1)] <= push_i.r1;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) out_q <= mem_q[rptr_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[rtl/core/json_key_string_extractor.sv]
// Extracts the string value of one configured key from a JSON byte stream. One byte
// is accepted per cycle while in_stall_o is low; the search for the quoted key is
// a parallel compare over an 18-byte window, so the parser never waits on its own
// work. A byte yields zero, one or two result beats, which go through a four-entry
// queue to a registered output; the input stalls only when fewer than two queue
// slots are free, which happens only when the consumer holds off. The second beat
// of a byte follows its first. On a failure beat (status 2) the consumer drops the
// characters of that extraction. Key registers sit at 0x00, 0x08 and 0x10 and
// should be written between documents.
module json_key_string_extractor #(
  parameter int unsigned MAX_KEY_CHARS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        doc_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  char_out_o,
  output logic [1:0]  status_o,
  output logic        run_end_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import jkse_pkg::*;

  logic [63:0]      key_low_q, key_high_q;
  logic [LEN_W-1:0] key_len_q;
  logic             cfg_wr;
  logic [1:0]       reg_idx;
  logic             room;
  logic             accept;
  push_t            push;
  result_t          res;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_KEY_LOW:  key_low_q  <= pwdata;
        REG_KEY_HIGH: key_high_q <= pwdata;
        REG_KEY_LEN:  key_len_q  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY_LOW:  prdata = key_low_q;
      REG_KEY_HIGH: prdata = key_high_q;
      REG_KEY_LEN:  prdata = {{(64 - LEN_W){1'b0}}, key_len_q};
      default:      prdata = '0;
    endcase
  end

  // Input handshake
  assign accept     = in_valid_i && room;
  assign in_stall_o = !room;

  jkse_front #(
    .MAX_KEY_CHARS(MAX_KEY_CHARS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .doc_last_i  (doc_last_i),
    .key_low_i   (key_low_q),
    .key_high_i  (key_high_q),
    .key_len_i   (key_len_q),
    .push_o      (push)
  );

  jkse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (res)
  );

  assign char_out_o = res.char_out;
  assign status_o   = res.status;
  assign run_end_o  = res.run_end;

endmodule

[rtl/core/jkse_checker.sv]
module jkse_props (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] char_out_o,
  input logic [1:0] status_o,
  input logic       run_end_o
);
  import jkse_pkg::*;

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_out_o)
      && $stable(status_o) && $stable(run_end_o))
    else $error("result beat changed while stalled");

  // Only defined status codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_CHAR) || (status_o == ST_DONE) || (status_o == ST_FAIL))
    else $error("undefined status code");

  // Run end exactly on terminal beats
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (run_end_o == (status_o != ST_CHAR)))
    else $error("run_end does not match status");

  // Terminal beats carry no character
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_CHAR) |-> (char_out_o == 8'h00))
    else $error("character on terminal beat");

endmodule

bind json_key_string_extractor jkse_props u_jkse_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .char_out_o  (char_out_o),
  .status_o    (status_o),
  .run_end_o   (run_end_o)
);
